>>> design/oes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_pkg
// Shared types and constants of the onset event sequencer.
// ----------------------------------------------------------------------------
package oes_pkg;

	localparam int CMD_W    = 3;
	localparam int ONSET_W  = 20;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 21;
	localparam int STATUS_W = 2;
	localparam int QDEPTH   = 2;

	localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] ONSET_TOP = {1'b0, {ONSET_W{1'b1}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_PLAY   = 3'd1,
		CMD_TICK   = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALUE   = 2'd0,
		ST_NO_PLAY = 2'd1,
		ST_NO_STOP = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                 op;
		logic [ONSET_W-1:0]   onset;
		logic [VALUE_W-1:0]   value;
	} item_t;

endpackage
`default_nettype wire

>>> design/oes_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_front
// Accepts command words, drops unused codes and pushes the rest to the queue.
// ----------------------------------------------------------------------------
module oes_front (
	input  wire logic                        start,
	input  wire logic [oes_pkg::CMD_W-1:0]   command,
	input  wire logic [oes_pkg::ONSET_W-1:0] onset,
	input  wire logic [oes_pkg::VALUE_W-1:0] new_value,
	input  wire logic                        q_full,
	output logic                             busy,
	output logic                             push,
	output oes_pkg::item_t                   item
);
	import oes_pkg::*;

	logic known;

	always_comb begin
		item.onset = onset;
		item.value = new_value;
		known      = 1'b1;
		unique case (command)
			CMD_INSERT: item.op = CMD_INSERT;
			CMD_PLAY:   item.op = CMD_PLAY;
			CMD_TICK:   item.op = CMD_TICK;
			CMD_STOP:   item.op = CMD_STOP;
			CMD_CLEAR:  item.op = CMD_CLEAR;
			default: begin
				item.op = CMD_TICK;
				known   = 1'b0;
			end
		endcase
	end

	assign busy = q_full;
	// drop unused codes at the door
	assign push = start && !q_full && known;

endmodule
`default_nettype wire

>>> design/oes_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module oes_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire oes_pkg::item_t item_in,
	input  wire logic           pop,
	output logic                full,
	output logic                empty,
	output oes_pkg::item_t      head
);
	import oes_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FW = $clog2(QDEPTH + 1);

	item_t          slot_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;

	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full  = (fill_q == FW'(QDEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= step(wr_ptr_q);
			if (pop)
				rd_ptr_q <= step(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + FW'(1);
			else if (pop && !push)
				fill_q <= fill_q - FW'(1);
		end
	end

endmodule
`default_nettype wire

>>> design/oes_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_back
// Executes queued words: entry search, insert, tick and value emission.
// ----------------------------------------------------------------------------
module oes_back #(
	parameter int MAX_ENTRIES      = 64,
	parameter int VALUES_PER_ONSET = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         empty,
	input  wire oes_pkg::item_t               head,
	output logic                              pop,
	output logic                              result_strobe,
	output logic [oes_pkg::VALUE_W-1:0]       out_value,
	output logic [oes_pkg::POS_W-1:0]         out_onset,
	output logic [oes_pkg::STATUS_W-1:0]      status,
	output logic                              last
);
	import oes_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int VW = $clog2(VALUES_PER_ONSET + 1);
	localparam int SD = MAX_ENTRIES * VALUES_PER_ONSET;
	localparam int SW = $clog2(SD);

	typedef enum logic [1:0] {S_IDLE, S_TICK, S_SEARCH, S_EMIT} state_t;

	logic [ONSET_W-1:0] onset_mem [MAX_ENTRIES];
	logic [VW-1:0]      cnt_mem   [MAX_ENTRIES];
	logic [VALUE_W-1:0] value_mem [SD];

	state_t             state_q;
	cmd_t               op_q;
	logic [ONSET_W-1:0] key_q;
	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      idx_q;
	logic               cmp_vld_q;
	logic [AW-1:0]      cmp_idx_q;
	logic [ONSET_W-1:0] onset_rd_q;
	logic [VW-1:0]      cnt_rd_q;
	logic [VALUE_W-1:0] value_rd_q;
	logic [SW-1:0]      base_q;
	logic [VW-1:0]      k_q;
	logic [VW-1:0]      emit_cnt_q;
	logic [CW-1:0]      count_q;
	logic [ONSET_W-1:0] latest_q;
	logic [POS_W-1:0]   pos_q;
	logic               running_q;
	logic               ever_q;
	logic               strobe_q;
	status_t            status_q;
	logic               last_q;
	logic [POS_W-1:0]   onset_out_q;

	logic               hit;
	logic               more;
	logic               miss;
	logic               rd_en;
	logic               ins_app;
	logic               ins_new;
	logic               val_re;
	logic [SW-1:0]      hit_base;
	logic [SW-1:0]      new_base;
	logic [AW-1:0]      cnt_wa;
	logic [VW-1:0]      cnt_wd;
	logic [SW-1:0]      val_wa;
	logic [POS_W-1:0]   pos_next;

	assign pop      = (state_q == S_IDLE) && !empty;
	assign hit      = cmp_vld_q && (onset_rd_q == key_q);
	assign more     = (idx_q < count_q);
	assign miss     = !hit && !more && !cmp_vld_q;
	assign rd_en    = (state_q == S_SEARCH) && !hit && more;
	assign hit_base = SW'(cmp_idx_q * VALUES_PER_ONSET);
	assign new_base = SW'(count_q[AW-1:0] * VALUES_PER_ONSET);
	assign ins_app  = (state_q == S_SEARCH) && (op_q == CMD_INSERT) && hit
			&& (cnt_rd_q < VW'(VALUES_PER_ONSET));
	assign ins_new  = (state_q == S_SEARCH) && (op_q == CMD_INSERT) && miss
			&& (count_q < CW'(MAX_ENTRIES));
	assign cnt_wa   = ins_app ? cmp_idx_q : count_q[AW-1:0];
	assign cnt_wd   = ins_app ? cnt_rd_q + VW'(1) : VW'(1);
	assign val_wa   = ins_app ? hit_base + SW'(cnt_rd_q) : new_base;
	assign val_re   = (state_q == S_EMIT) && (k_q < emit_cnt_q);
	assign pos_next = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_ff @(posedge clk) begin
		if (ins_new)
			onset_mem[count_q[AW-1:0]] <= key_q;
		if (rd_en)
			onset_rd_q <= onset_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ins_app || ins_new)
			cnt_mem[cnt_wa] <= cnt_wd;
		if (rd_en)
			cnt_rd_q <= cnt_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ins_app || ins_new)
			value_mem[val_wa] <= value_q;
		if (val_re)
			value_rd_q <= value_mem[base_q + SW'(k_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= CMD_TICK;
			key_q       <= '0;
			value_q     <= '0;
			idx_q       <= '0;
			cmp_vld_q   <= 1'b0;
			cmp_idx_q   <= '0;
			base_q      <= '0;
			k_q         <= '0;
			emit_cnt_q  <= '0;
			count_q     <= '0;
			latest_q    <= '0;
			pos_q       <= '0;
			running_q   <= 1'b0;
			ever_q      <= 1'b0;
			strobe_q    <= 1'b0;
			status_q    <= ST_VALUE;
			last_q      <= 1'b0;
			onset_out_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						op_q      <= head.op;
						key_q     <= head.onset;
						value_q   <= head.value;
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						unique case (head.op)
							CMD_INSERT: state_q <= S_SEARCH;
							CMD_PLAY: begin
								if (count_q == '0) begin
									pos_q       <= '0;
									strobe_q    <= 1'b1;
									status_q    <= ST_NO_PLAY;
									last_q      <= 1'b1;
									onset_out_q <= '0;
								end else begin
									pos_q     <= {1'b0, head.onset};
									running_q <= 1'b1;
									ever_q    <= 1'b1;
									state_q   <= S_TICK;
								end
							end
							CMD_TICK: begin
								if (running_q)
									state_q <= S_TICK;
							end
							CMD_STOP: begin
								if (!ever_q) begin
									strobe_q    <= 1'b1;
									status_q    <= ST_NO_STOP;
									last_q      <= 1'b1;
									onset_out_q <= '0;
								end else begin
									running_q <= 1'b0;
								end
							end
							CMD_CLEAR: begin
								count_q   <= '0;
								latest_q  <= '0;
								running_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_TICK: begin
					if (!({1'b0, latest_q} > pos_q))
						running_q <= 1'b0;
					pos_q     <= pos_next;
					key_q     <= pos_next[ONSET_W-1:0];
					idx_q     <= '0;
					cmp_vld_q <= 1'b0;
					if (pos_next > ONSET_TOP)
						state_q <= S_IDLE;
					else
						state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					priority if (hit) begin
						cmp_vld_q <= 1'b0;
						if (op_q == CMD_INSERT) begin
							if (!ins_app) begin
								strobe_q    <= 1'b1;
								status_q    <= ST_FULL;
								last_q      <= 1'b1;
								onset_out_q <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							base_q     <= hit_base;
							emit_cnt_q <= cnt_rd_q;
							k_q        <= '0;
							state_q    <= S_EMIT;
						end
					end else if (more) begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= idx_q[AW-1:0];
						idx_q     <= idx_q + CW'(1);
					end else if (cmp_vld_q) begin
						cmp_vld_q <= 1'b0;
					end else begin
						if (op_q == CMD_INSERT) begin
							if (ins_new) begin
								count_q <= count_q + CW'(1);
								if (key_q > latest_q)
									latest_q <= key_q;
							end else begin
								strobe_q    <= 1'b1;
								status_q    <= ST_FULL;
								last_q      <= 1'b1;
								onset_out_q <= '0;
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (val_re) begin
						strobe_q    <= 1'b1;
						status_q    <= ST_VALUE;
						last_q      <= ((k_q + VW'(1)) == emit_cnt_q);
						onset_out_q <= pos_q;
						k_q         <= k_q + VW'(1);
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign out_value     = (status_q == ST_VALUE) ? value_rd_q : '0;
	assign out_onset     = onset_out_q;
	assign status        = status_q;
	assign last          = last_q;

	a_run_started: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> ever_q)
		else $error("running without a successful play");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q != ST_VALUE) |-> (last_q && onset_out_q == '0))
		else $error("error word not final or carries a position");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q == ST_VALUE) |-> (onset_out_q != '0 && onset_out_q <= ONSET_TOP))
		else $error("value emitted at impossible position");

endmodule
`default_nettype wire

>>> design/onset_event_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onset_event_sequencer
// Millisecond event sequencer: stores value handles under onsets and plays
// them back one tick at a time.
//
//   channel  | handshake               | words
//   ---------+-------------------------+-----------------------------------
//   command  | start, busy             | command, onset, new_value
//   result   | result_strobe (1 cycle) | out_value, out_onset, status, last
//
// A word is taken when start is high and busy is low; busy rises only when
// the two-word command queue is full.
// Insert and tick search the entry table one entry per cycle; a tick then
// emits one result per value stored under the onset that it reaches.
// Stop, clear and a failed play are finished without a table search.
// Reset clears the queue, counters and flags; no table sweep is needed.
// Results cannot be held off: result_strobe marks each for one cycle only.
// ----------------------------------------------------------------------------
module onset_event_sequencer #(
	parameter int MAX_ENTRIES      = 64,
	parameter int VALUES_PER_ONSET = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [oes_pkg::CMD_W-1:0]      command,
	input  wire logic [oes_pkg::ONSET_W-1:0]    onset,
	input  wire logic [oes_pkg::VALUE_W-1:0]    new_value,
	output logic                                result_strobe,
	output logic [oes_pkg::VALUE_W-1:0]         out_value,
	output logic [oes_pkg::POS_W-1:0]           out_onset,
	output logic [oes_pkg::STATUS_W-1:0]        status,
	output logic                                last
);
	import oes_pkg::*;

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t item;
	item_t head;

	oes_front u_front (
		.start     (start),
		.command   (command),
		.onset     (onset),
		.new_value (new_value),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.item      (item)
	);

	oes_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item_in (item),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	oes_back #(
		.MAX_ENTRIES      (MAX_ENTRIES),
		.VALUES_PER_ONSET (VALUES_PER_ONSET)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.head          (head),
		.pop           (pop),
		.result_strobe (result_strobe),
		.out_value     (out_value),
		.out_onset     (out_onset),
		.status        (status),
		.last          (last)
	);

endmodule
`default_nettype wire
